// ===== rtl/core/sfd_pkg.sv =====
// Shared types, constants and helpers for the S.BUS frame decoder.
// No dependencies; imported by sfd_burst and sbus_frame_decoder.
package sfd_pkg;

   localparam int FRAME_BYTES = 25;
   localparam int NUM_CHAN    = 16;
   localparam int CHAN_BITS   = 11;
   localparam int CHAN_DATA_W = NUM_CHAN * CHAN_BITS;
   localparam int HOLD_BYTES  = FRAME_BYTES - 2;
   localparam int HOLD_W      = HOLD_BYTES * 8;
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int CNT_W       = $clog2(NUM_CHAN + 1);
   localparam int IDX_W       = $clog2(NUM_CHAN);

   localparam logic [7:0] HDR_BYTE = 8'h0F;
   localparam int FS_BIT   = 3;
   localparam int LOST_BIT = 2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd50;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic KIND_CHAN    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } sfd_req_type;

   typedef struct packed {
      logic                 kind;
      logic [IDX_W-1:0]     channel_index;
      logic [CHAN_BITS-1:0] channel_value;
      logic                 failsafe;
      logic                 lost_frame;
      logic                 last;
   } sfd_rsp_type;

   typedef struct packed {
      logic                   valid;
      logic                   kind;
      logic                   failsafe;
      logic                   lost_frame;
      logic [CHAN_DATA_W-1:0] data;
   } sfd_load_type;

   function automatic logic footer_ok(input logic [7:0] b);
      return (b == 8'h00) || (b == 8'h04) || (b == 8'h14) || (b == 8'h24) || (b == 8'h34);
   endfunction

endpackage

// ===== rtl/core/sfd_burst.sv =====
// Result sequencer: turns one loaded frame or timeout event into result items.
// Holds the output register of the result channel. Depends on sfd_pkg.
module sfd_burst import sfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  sfd_load_type load,
   output logic         idle,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sfd_rsp_type  rsp_data
);

   logic [CHAN_DATA_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   kind_ff, kind_in;
   logic                   fs_ff, fs_in;
   logic                   lost_ff, lost_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sfd_rsp_type            rsp_data_ff, rsp_data_in;
   logic                   advance;

   assign advance = (cnt_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign idle    = (cnt_ff == '0);

   always_comb begin
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      fs_in        = fs_ff;
      lost_in      = lost_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load.valid) begin
         sh_in   = load.data;
         cnt_in  = (load.kind == KIND_TIMEOUT) ? CNT_W'(1) : CNT_W'(NUM_CHAN);
         idx_in  = '0;
         kind_in = load.kind;
         fs_in   = load.failsafe;
         lost_in = load.lost_frame;
      end else if (advance) begin
         rsp_data_in.kind          = kind_ff;
         rsp_data_in.channel_index = (kind_ff == KIND_TIMEOUT) ? '0 : idx_ff;
         rsp_data_in.channel_value = (kind_ff == KIND_TIMEOUT) ? '0 : sh_ff[CHAN_BITS-1:0];
         rsp_data_in.failsafe      = fs_ff;
         rsp_data_in.lost_frame    = lost_ff;
         rsp_data_in.last          = (cnt_ff == CNT_W'(1));
         rsp_valid_in = 1'b1;
         sh_in  = sh_ff >> CHAN_BITS;
         cnt_in = cnt_ff - CNT_W'(1);
         idx_in = idx_ff + IDX_W'(1);
      end
      if (!advance && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sh_ff       <= sh_in;
      idx_ff      <= idx_in;
      kind_ff     <= kind_in;
      fs_ff       <= fs_in;
      lost_ff     <= lost_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load.valid |-> cnt_ff == '0)
      else $error("load while burst pending");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(NUM_CHAN))
      else $error("burst count out of range");

   a_timeout_single: assert property (@(posedge clock) disable iff (reset)
      load.valid && load.kind == KIND_TIMEOUT |=> cnt_ff == CNT_W'(1))
      else $error("timeout event not a single item");

   a_timeout_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.kind == KIND_TIMEOUT |-> rsp_data_ff.last)
      else $error("timeout item not marked last");

endmodule

// ===== rtl/core/sbus_frame_decoder.sv =====
// S.BUS frame decoder top level: header hunt, frame collection, footer check,
// tick timeout and failsafe. Depends on sfd_pkg and sfd_burst.
//
//   channel  ports                         moves
//   req      req_valid/req_ready/req_data  byte or millisecond tick
//   rsp      rsp_valid/rsp_ready/rsp_data  channel value or timeout event
//   csr      csr_we/csr_wdata              timeout_ticks write
//
// An item that yields no result is taken one per cycle while the sequencer is idle.
// A good frame yields 16 items, one per cycle from the sequencer while rsp_ready is high; a timeout one.
// req_ready is low while the sequencer still has items not yet in the output
// register, so a frame stalls the input until all its items are in that register.
// Reset is synchronous: hunting, flags cleared, tick count 0, timeout 50.
module sbus_frame_decoder import sfd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  sfd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output sfd_rsp_type rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0]       timeout_ff, timeout_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic              fs_ff, fs_in;
   logic              lost_ff, lost_in;
   logic [15:0]       ticks_ff, ticks_in;
   logic [15:0]       ticks_next;
   logic              take;
   logic              idle;
   sfd_load_type      load;

   assign req_ready  = idle;
   assign take       = req_valid && req_ready;
   assign ticks_next = (ticks_ff == 16'hFFFF) ? ticks_ff : ticks_ff + 16'd1;

   always_comb begin
      timeout_in      = csr_we ? csr_wdata : timeout_ff;
      pos_in          = pos_ff;
      hold_in         = hold_ff;
      fs_in           = fs_ff;
      lost_in         = lost_ff;
      ticks_in        = ticks_ff;
      load.valid      = 1'b0;
      load.kind       = KIND_CHAN;
      load.failsafe   = fs_ff;
      load.lost_frame = lost_ff;
      load.data       = '0;
      if (take) begin
         if (req_data.opcode == OP_TICK) begin
            ticks_in = ticks_next;
            if (ticks_next > timeout_ff) begin
               fs_in = 1'b1;
               if (!fs_ff) begin
                  load.valid      = 1'b1;
                  load.kind       = KIND_TIMEOUT;
                  load.failsafe   = 1'b1;
                  load.lost_frame = lost_ff;
               end
            end
         end else if (pos_ff == '0) begin
            if (req_data.rx_byte == HDR_BYTE) begin
               pos_in = POS_W'(1);
            end
         end else if (pos_ff == POS_W'(FRAME_BYTES - 1)) begin
            pos_in = '0;
            if (footer_ok(req_data.rx_byte)) begin
               fs_in           = hold_ff[HOLD_W-8+FS_BIT];
               lost_in         = hold_ff[HOLD_W-8+LOST_BIT];
               ticks_in        = '0;
               load.valid      = 1'b1;
               load.kind       = KIND_CHAN;
               load.failsafe   = hold_ff[HOLD_W-8+FS_BIT];
               load.lost_frame = hold_ff[HOLD_W-8+LOST_BIT];
               load.data       = hold_ff[CHAN_DATA_W-1:0];
            end
         end else begin
            hold_in = {req_data.rx_byte, hold_ff[HOLD_W-1:8]};
            pos_in  = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         pos_ff     <= '0;
         fs_ff      <= 1'b0;
         lost_ff    <= 1'b0;
         ticks_ff   <= '0;
      end else begin
         timeout_ff <= timeout_in;
         pos_ff     <= pos_in;
         fs_ff      <= fs_in;
         lost_ff    <= lost_in;
         ticks_ff   <= ticks_in;
      end
      hold_ff <= hold_in;
   end

   sfd_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .idle      (idle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(FRAME_BYTES))
      else $error("byte position out of range");

   a_good_frame_clears: assert property (@(posedge clock) disable iff (reset)
      load.valid && load.kind == KIND_CHAN |=> ticks_ff == '0)
      else $error("tick count not cleared on good frame");

   a_timeout_sets_fs: assert property (@(posedge clock) disable iff (reset)
      load.valid && load.kind == KIND_TIMEOUT |=> fs_ff && !$past(fs_ff))
      else $error("timeout event without failsafe edge");

endmodule
